// ----- hdl/pfc_pkg.sv -----
package pfc_pkg;

    localparam int SQUARE_SIDE  = 5;
    localparam int CELL_COUNT   = SQUARE_SIDE * SQUARE_SIDE;
    localparam int LETTER_COUNT = 26;
    localparam int LETTER_W     = 5;
    localparam int POS_W        = $clog2(SQUARE_SIDE);
    localparam int FILL_W       = $clog2(CELL_COUNT + 1);

    localparam logic [LETTER_W-1:0] LETTER_I = LETTER_W'(8);
    localparam logic [LETTER_W-1:0] LETTER_J = LETTER_W'(9);
    localparam logic [LETTER_W-1:0] LETTER_Z = LETTER_W'(25);

    typedef enum logic [2:0] {
        CMD_CLEAR   = 3'd0,
        CMD_KEY     = 3'd1,
        CMD_FINISH  = 3'd2,
        CMD_ENCRYPT = 3'd3,
        CMD_DECRYPT = 3'd4
    } pfc_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_LOCATE,
        ST_SELECT
    } pfc_state_t;

    typedef struct packed {
        logic [2:0]          cmd;
        logic [LETTER_W-1:0] first_letter;
        logic [LETTER_W-1:0] second_letter;
    } pfc_in_t;

    typedef struct packed {
        logic [LETTER_W-1:0] first_out;
        logic [LETTER_W-1:0] second_out;
        logic                not_ready;
    } pfc_out_t;

    // pair letters as looked up in the square
    typedef struct packed {
        logic [LETTER_W-1:0] a;
        logic [LETTER_W-1:0] b;
    } pfc_look_t;

    // row and column of the two output cells
    typedef struct packed {
        logic [POS_W-1:0] r1;
        logic [POS_W-1:0] c1;
        logic [POS_W-1:0] r2;
        logic [POS_W-1:0] c2;
    } pfc_target_t;

    typedef struct packed {
        logic                match_a;
        logic                match_b;
        logic [LETTER_W-1:0] pick_a;
        logic [LETTER_W-1:0] pick_b;
    } pfc_lane_out_t;

    // saturate above z, then j is taken as i
    function automatic logic [LETTER_W-1:0] norm_letter(input logic [LETTER_W-1:0] l);
        logic [LETTER_W-1:0] s;
        s = (l > LETTER_Z) ? LETTER_Z : l;
        return (s == LETTER_J) ? LETTER_I : s;
    endfunction

    // one place forward or back around the square
    function automatic logic [POS_W-1:0] step_pos(input logic [POS_W-1:0] p,
                                                  input logic back);
        logic [POS_W-1:0] r;
        if (back)
            r = (p == '0) ? POS_W'(SQUARE_SIDE - 1) : p - POS_W'(1);
        else
            r = (p == POS_W'(SQUARE_SIDE - 1)) ? '0 : p + POS_W'(1);
        return r;
    endfunction

endpackage

// ----- hdl/pfc_lane.sv -----
module pfc_lane
    import pfc_pkg::*;
#(
    parameter int ROW = 0,
    parameter int COL = 0
)
(
    input  logic                clk,
    input  logic                wr_en,
    input  logic [LETTER_W-1:0] wr_letter,
    input  pfc_look_t           look,
    input  pfc_target_t         target,
    output pfc_lane_out_t       lane_out
);

    logic [LETTER_W-1:0] cell_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cell_reg <= wr_letter;
        end
    end

    // match the pair letters, and offer this cell if it is a target
    always_comb
    begin
        lane_out.match_a = (cell_reg == look.a);
        lane_out.match_b = (cell_reg == look.b);
        lane_out.pick_a  = (target.r1 == POS_W'(ROW) && target.c1 == POS_W'(COL))
                           ? cell_reg : '0;
        lane_out.pick_b  = (target.r2 == POS_W'(ROW) && target.c2 == POS_W'(COL))
                           ? cell_reg : '0;
    end

endmodule

// ----- hdl/pfc_merge.sv -----
module pfc_merge
    import pfc_pkg::*;
(
    input  logic [CELL_COUNT-1:0] match_a,
    input  logic [CELL_COUNT-1:0] match_b,
    input  logic                  decrypt,
    output pfc_target_t           target
);

    logic [POS_W-1:0] r1;
    logic [POS_W-1:0] c1;
    logic [POS_W-1:0] r2;
    logic [POS_W-1:0] c2;

    // one-hot lane matches to row and column
    always_comb
    begin
        r1 = '0;
        c1 = '0;
        r2 = '0;
        c2 = '0;
        for (int k = 0; k < CELL_COUNT; k++)
        begin
            if (match_a[k])
            begin
                r1 = r1 | POS_W'(k / SQUARE_SIDE);
                c1 = c1 | POS_W'(k % SQUARE_SIDE);
            end
            if (match_b[k])
            begin
                r2 = r2 | POS_W'(k / SQUARE_SIDE);
                c2 = c2 | POS_W'(k % SQUARE_SIDE);
            end
        end
    end

    always_comb
    begin
        if (r1 == r2)
        begin
            target.r1 = r1;
            target.c1 = step_pos(c1, decrypt);
            target.r2 = r2;
            target.c2 = step_pos(c2, decrypt);
        end
        else if (c1 == c2)
        begin
            target.r1 = step_pos(r1, decrypt);
            target.c1 = c1;
            target.r2 = step_pos(r2, decrypt);
            target.c2 = c2;
        end
        else
        begin
            target.r1 = r1;
            target.c1 = c2;
            target.r2 = r2;
            target.c2 = c1;
        end
    end

endmodule

// ----- hdl/playfair_digraph_cipher.sv -----
// playfair cipher on a 5x5 key square, letters coded 0 for a to 25 for z.
// a transaction is taken when start is high and busy is low. clear and key
// letter leave busy low; finish walks the alphabet, one letter a cycle, and
// keeps busy high while it walks; an encrypt or decrypt pair passes through
// the 25 compare lanes and then the output select, and its result shows on
// result with valid high for exactly one cycle, after the LOCATE and SELECT
// states (a pair sent before finish answers in the next cycle with not_ready
// set and zero letters). the receiver cannot stall: a result is gone after
// its one cycle. key square cells have no reset; they are all written by
// the time a pair can read them.
module playfair_digraph_cipher
    import pfc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  pfc_in_t  command,
    output logic     valid,
    output pfc_out_t result
);

    pfc_state_t state_reg;
    pfc_state_t state_next;

    logic [LETTER_COUNT-1:0] used_reg;
    logic [LETTER_COUNT-1:0] used_next;
    logic [FILL_W-1:0]       fill_reg;
    logic [FILL_W-1:0]       fill_next;
    logic                    ready_reg;
    logic                    ready_next;
    logic [LETTER_W-1:0]     walk_reg;
    logic [LETTER_W-1:0]     walk_next;

    pfc_look_t   look_reg;
    logic        decrypt_reg;
    pfc_target_t target_reg;
    pfc_target_t target_comb;

    logic     valid_reg;
    logic     valid_next;
    pfc_out_t result_reg;
    pfc_out_t result_next;

    // fsm outputs
    logic accept;
    logic fill_active;
    logic locate_en;
    logic select_en;

    logic                is_pair;
    logic [LETTER_W-1:0] place_letter;
    logic                place_req;
    logic                used_hit;
    logic                place_en;

    logic [CELL_COUNT-1:0] match_a;
    logic [CELL_COUNT-1:0] match_b;
    pfc_lane_out_t         lane_out [CELL_COUNT];
    logic [LETTER_W-1:0]   pick_a;
    logic [LETTER_W-1:0]   pick_b;

    assign is_pair = (command.cmd == CMD_ENCRYPT) || (command.cmd == CMD_DECRYPT);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (command.cmd == CMD_FINISH)
                        state_next = ST_FILL;
                    else if (is_pair && ready_reg)
                        state_next = ST_LOCATE;
                end
            end
            ST_FILL:
            begin
                if (walk_reg == LETTER_W'(LETTER_COUNT - 1))
                    state_next = ST_IDLE;
            end
            ST_LOCATE: state_next = ST_SELECT;
            ST_SELECT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // fsm outputs
    always_comb
    begin
        busy        = 1'b1;
        accept      = 1'b0;
        fill_active = 1'b0;
        locate_en   = 1'b0;
        select_en   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy   = 1'b0;
                accept = start;
            end
            ST_FILL:   fill_active = 1'b1;
            ST_LOCATE: locate_en   = 1'b1;
            ST_SELECT: select_en   = 1'b1;
            default:   busy        = 1'b1;
        endcase
    end

    // letter placement, shared by key letter and the finish walk
    assign place_letter = fill_active ? walk_reg : command.first_letter;
    assign place_req    = fill_active || (accept && command.cmd == CMD_KEY);
    assign used_hit     = |(used_reg & (LETTER_COUNT'(1) << place_letter));
    assign place_en     = place_req
                          && (place_letter < LETTER_W'(LETTER_COUNT))
                          && (place_letter != LETTER_J)
                          && !used_hit
                          && (fill_reg < FILL_W'(CELL_COUNT));

    always_comb
    begin
        used_next  = used_reg;
        fill_next  = fill_reg;
        ready_next = ready_reg;
        walk_next  = walk_reg;
        if (accept && command.cmd == CMD_CLEAR)
        begin
            used_next  = LETTER_COUNT'(1) << LETTER_J;
            fill_next  = '0;
            ready_next = 1'b0;
        end
        if (place_en)
        begin
            used_next = used_reg | (LETTER_COUNT'(1) << place_letter);
            fill_next = fill_reg + FILL_W'(1);
        end
        if (accept && command.cmd == CMD_FINISH)
            walk_next = '0;
        if (fill_active)
        begin
            walk_next = walk_reg + LETTER_W'(1);
            if (walk_reg == LETTER_W'(LETTER_COUNT - 1))
                ready_next = 1'b1;
        end
    end

    // compare lanes, one per square cell
    for (genvar r = 0; r < SQUARE_SIDE; r++)
    begin : g_row
        for (genvar c = 0; c < SQUARE_SIDE; c++)
        begin : g_col
            pfc_lane #(
                .ROW (r),
                .COL (c)
            ) u_lane (
                .clk       (clk),
                .wr_en     (place_en && fill_reg == FILL_W'(r * SQUARE_SIDE + c)),
                .wr_letter (place_letter),
                .look      (look_reg),
                .target    (target_reg),
                .lane_out  (lane_out[r * SQUARE_SIDE + c])
            );
        end
    end

    // gather lane matches and picks
    always_comb
    begin
        pick_a = '0;
        pick_b = '0;
        for (int k = 0; k < CELL_COUNT; k++)
        begin
            match_a[k] = lane_out[k].match_a;
            match_b[k] = lane_out[k].match_b;
            pick_a     = pick_a | lane_out[k].pick_a;
            pick_b     = pick_b | lane_out[k].pick_b;
        end
    end

    pfc_merge u_merge (
        .match_a (match_a),
        .match_b (match_b),
        .decrypt (decrypt_reg),
        .target  (target_comb)
    );

    // result register
    always_comb
    begin
        valid_next  = 1'b0;
        result_next = result_reg;
        if (accept && is_pair && !ready_reg)
        begin
            valid_next  = 1'b1;
            result_next = '{first_out: '0, second_out: '0, not_ready: 1'b1};
        end
        else if (select_en)
        begin
            valid_next  = 1'b1;
            result_next = '{first_out: pick_a, second_out: pick_b, not_ready: 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            used_reg  <= LETTER_COUNT'(1) << LETTER_J;
            fill_reg  <= '0;
            ready_reg <= 1'b0;
            walk_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            fill_reg  <= fill_next;
            ready_reg <= ready_next;
            walk_reg  <= walk_next;
            valid_reg <= valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (accept && is_pair)
        begin
            look_reg.a  <= norm_letter(command.first_letter);
            look_reg.b  <= norm_letter(command.second_letter);
            decrypt_reg <= (command.cmd == CMD_DECRYPT);
        end
        if (locate_en)
        begin
            target_reg <= target_comb;
        end
    end

    assign valid  = valid_reg;
    assign result = result_reg;

    // a finished square holds every letter but j exactly once
    a_lane_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        locate_en |-> ($onehot(match_a) && $onehot(match_b)))
        else $error("pair letter not found exactly once in key square");

    a_j_never_placed: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg[LETTER_J] && fill_reg <= FILL_W'(CELL_COUNT))
        else $error("j cleared or fill position past end of square");

    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> (fill_reg == FILL_W'(CELL_COUNT)))
        else $error("square marked ready before it is full");

    a_cipher_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !result_reg.not_ready) |-> (ready_reg && !busy))
        else $error("cipher result without a finished square");

    a_select_result: assert property (@(posedge clk) disable iff (!rst_n)
        select_en |=> (valid_reg && $past(state_reg) == ST_SELECT))
        else $error("select cycle gave no result");

endmodule

// ----- test/tb_playfair_digraph_cipher.sv -----
module tb_playfair_digraph_cipher
    import pfc_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // opcodes the block must ignore without answering
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

    // stop point for the random part, counting every queued transaction
    localparam int RANDOM_ITEMS = 1225;
    // worst case is roughly 1300 transactions, each with the longest gap and a full finish walk
    localparam int CYCLE_LIMIT  = 400000;
    // covers the busy time of a finish and the answer of a last pair
    localparam int DRAIN_CYCLES = 40;

    logic     clk;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    pfc_in_t  command = '0;
    logic     valid;
    pfc_out_t result;

    playfair_digraph_cipher u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .command (command),
        .valid   (valid),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predicted state of the key square, kept in step with each accepted
    // transaction; reset gives only j marked as used and no square yet
    // ------------------------------------------------------------------
    logic [LETTER_W-1:0]     key_sq [CELL_COUNT];
    logic [LETTER_COUNT-1:0] letter_taken = LETTER_COUNT'(1) << LETTER_J;
    int                      next_cell    = 0;
    logic                    square_done  = 1'b0;

    // pair results still owed by the block, oldest first
    pfc_out_t cipher_pairs_due [$];
    // transactions waiting for the driver
    pfc_in_t  command_queue [$];

    int error_count = 0;
    int cycle_count = 0;

    // keyword letter: skipped when out of range, j, already placed or square full
    function automatic void place_key_letter(input int letter);
        if (letter < LETTER_COUNT && letter != int'(LETTER_J) && !letter_taken[letter]
            && next_cell < CELL_COUNT)
        begin
            key_sq[next_cell] = LETTER_W'(letter);
            next_cell++;
            letter_taken[letter] = 1'b1;
        end
    endfunction

    // letters above z count as z, and j is looked up as i
    function automatic void find_cell(input logic [LETTER_W-1:0] letter,
                                      output int row, output int col);
        logic [LETTER_W-1:0] look;
        look = (letter > LETTER_Z) ? LETTER_Z : letter;
        if (look == LETTER_J)
            look = LETTER_I;
        row = 0;
        col = 0;
        // walk downwards so the lowest matching cell wins
        for (int k = CELL_COUNT - 1; k >= 0; k--)
        begin
            if (key_sq[k] == look)
            begin
                row = k / SQUARE_SIDE;
                col = k % SQUARE_SIDE;
            end
        end
    endfunction

    // apply one accepted transaction and queue the pair result it owes, if any
    function automatic void step_playfair(input pfc_in_t c);
        int       r1, c1, r2, c2, shift;
        pfc_out_t o;
        o = '0;
        case (c.cmd)
            CMD_CLEAR:
            begin
                letter_taken = LETTER_COUNT'(1) << LETTER_J;
                next_cell    = 0;
                square_done  = 1'b0;
            end
            CMD_KEY:
                place_key_letter(int'(c.first_letter));
            CMD_FINISH:
            begin
                for (int k = 0; k < LETTER_COUNT; k++)
                    place_key_letter(k);
                square_done = 1'b1;
            end
            CMD_ENCRYPT, CMD_DECRYPT:
            begin
                if (!square_done)
                    o.not_ready = 1'b1;
                else
                begin
                    // decrypt moves one back, i.e. side-1 forward modulo side
                    shift = (c.cmd == CMD_ENCRYPT) ? 1 : SQUARE_SIDE - 1;
                    find_cell(c.first_letter, r1, c1);
                    find_cell(c.second_letter, r2, c2);
                    if (r1 == r2)
                    begin
                        o.first_out  = key_sq[r1 * SQUARE_SIDE + (c1 + shift) % SQUARE_SIDE];
                        o.second_out = key_sq[r2 * SQUARE_SIDE + (c2 + shift) % SQUARE_SIDE];
                    end
                    else if (c1 == c2)
                    begin
                        o.first_out  = key_sq[((r1 + shift) % SQUARE_SIDE) * SQUARE_SIDE + c1];
                        o.second_out = key_sq[((r2 + shift) % SQUARE_SIDE) * SQUARE_SIDE + c2];
                    end
                    else
                    begin
                        // rectangle: each letter keeps its row and takes the other column
                        o.first_out  = key_sq[r1 * SQUARE_SIDE + c2];
                        o.second_out = key_sq[r2 * SQUARE_SIDE + c1];
                    end
                end
                cipher_pairs_due.push_back(o);
            end
            default:
                ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [LETTER_W-1:0] ltr(input byte ch);
        return LETTER_W'(ch - "A");
    endfunction

    function automatic void queue_command(input logic [2:0] op,
                                          input logic [LETTER_W-1:0] a,
                                          input logic [LETTER_W-1:0] b);
        pfc_in_t c;
        c.cmd           = op;
        c.first_letter  = a;
        c.second_letter = b;
        command_queue.push_back(c);
    endfunction

    // mostly real letters, now and then a code above z
    function automatic logic [LETTER_W-1:0] any_letter();
        if ($urandom_range(0, 9) == 0)
            return LETTER_W'($urandom_range(31, LETTER_COUNT));
        return LETTER_W'($urandom_range(LETTER_COUNT - 1, 0));
    endfunction

    // ------------------------------------------------------------------
    // driver: presents one transaction at a time on the falling edge and
    // holds it until an edge sees start high with busy low
    // ------------------------------------------------------------------
    logic handed_over = 1'b0;
    int   gap_left    = 0;
    int   calm_left   = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (start && !handed_over)
            ;   // still waiting on busy, keep the transaction on the port
        else if (gap_left > 0)
        begin
            start <= 1'b0;
            gap_left--;
        end
        else if (command_queue.size() != 0)
        begin
            start   <= 1'b1;
            command <= command_queue.pop_front();
            // now and then a run with no idling at all
            if (calm_left == 0 && $urandom_range(0, 24) == 0)
                calm_left = $urandom_range(80, 30);
            if (calm_left > 0)
            begin
                calm_left--;
                gap_left = 0;
            end
            else if ($urandom_range(0, 9) == 0)
                gap_left = $urandom_range(40, 8);
            else if ($urandom_range(0, 2) == 0)
                gap_left = 0;
            else
                gap_left = $urandom_range(3, 0);
        end
        else
            start <= 1'b0;
    end

    // ------------------------------------------------------------------
    // monitor: results are checked before the transaction accepted on the
    // same edge is predicted, since no result can belong to it yet
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        pfc_out_t want;
        if (rst_n)
        begin
            if (valid)
            begin
                if (cipher_pairs_due.size() == 0)
                begin
                    $error({"pair result with none outstanding: ",
                            "first_out %0d second_out %0d not_ready %0b"},
                           result.first_out, result.second_out, result.not_ready);
                    error_count++;
                end
                else
                begin
                    want = cipher_pairs_due.pop_front();
                    if (result.first_out !== want.first_out)
                    begin
                        $error("first_out: expected %0d, actual %0d",
                               want.first_out, result.first_out);
                        error_count++;
                    end
                    if (result.second_out !== want.second_out)
                    begin
                        $error("second_out: expected %0d, actual %0d",
                               want.second_out, result.second_out);
                        error_count++;
                    end
                    if (result.not_ready !== want.not_ready)
                    begin
                        $error("not_ready: expected %0b, actual %0b",
                               want.not_ready, result.not_ready);
                        error_count++;
                    end
                end
            end
            if (start && !busy)
                step_playfair(command);
            handed_over <= start && !busy;
        end
        else
            handed_over <= 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_playfair_digraph_cipher: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int counted;
        int key_count;
        int pair_count;
        int pick;
        logic [2:0] pair_op;

        // pairs before any square exists answer not ready
        queue_command(CMD_ENCRYPT, ltr("P"), ltr("L"));
        queue_command(CMD_DECRYPT, '0, LETTER_W'(31));
        // keyword playfir, with j, a repeated letter and an out of range code thrown in;
        // square becomes P L A Y F / I R B C D / E G H K M / N O Q S T / U V W X Z
        queue_command(CMD_KEY, ltr("P"), '0);
        queue_command(CMD_KEY, ltr("L"), '0);
        queue_command(CMD_KEY, ltr("A"), '0);
        queue_command(CMD_KEY, LETTER_J, '0);
        queue_command(CMD_KEY, ltr("Y"), '0);
        queue_command(CMD_KEY, ltr("A"), '0);
        queue_command(CMD_KEY, ltr("F"), '0);
        queue_command(CMD_KEY, LETTER_W'(LETTER_COUNT), '0);
        queue_command(CMD_KEY, ltr("I"), '0);
        queue_command(CMD_KEY, ltr("R"), '0);
        // unknown opcodes must be silent
        queue_command(CMD_SPARE_FIRST, ltr("A"), ltr("B"));
        queue_command(CMD_SPARE_LAST, LETTER_W'(31), LETTER_W'(31));
        // finish twice, then a key letter that can no longer land
        queue_command(CMD_FINISH, '0, '0);
        queue_command(CMD_FINISH, '0, '0);
        queue_command(CMD_KEY, ltr("B"), '0);
        // same row, same column, rectangle, j as i, doubled letter, saturation
        queue_command(CMD_ENCRYPT, ltr("P"), ltr("L"));
        queue_command(CMD_ENCRYPT, ltr("L"), ltr("G"));
        queue_command(CMD_ENCRYPT, ltr("H"), ltr("P"));
        queue_command(CMD_ENCRYPT, LETTER_J, ltr("R"));
        queue_command(CMD_ENCRYPT, ltr("O"), ltr("O"));
        queue_command(CMD_ENCRYPT, LETTER_W'(31), '0);
        queue_command(CMD_DECRYPT, ltr("P"), ltr("L"));
        queue_command(CMD_DECRYPT, ltr("L"), ltr("G"));
        queue_command(CMD_DECRYPT, LETTER_Z, LETTER_J);
        // clearing drops the square again
        queue_command(CMD_CLEAR, '0, '0);
        queue_command(CMD_ENCRYPT, ltr("A"), ltr("B"));

        // random sessions: mostly clear, keyword, finish, then a stream of pairs;
        // some skip the clear or the finish, and noise is mixed in throughout
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) != 0)
            begin
                queue_command(CMD_CLEAR, any_letter(), any_letter());
                counted++;
            end
            key_count = $urandom_range(14, 0);
            repeat (key_count)
            begin
                queue_command(CMD_KEY, any_letter(), any_letter());
                counted++;
            end
            if ($urandom_range(0, 7) == 0)
            begin
                pair_op = ($urandom_range(0, 1) == 0) ? CMD_ENCRYPT : CMD_DECRYPT;
                queue_command(pair_op, any_letter(), any_letter());
                counted++;
            end
            if ($urandom_range(0, 11) != 0)
            begin
                queue_command(CMD_FINISH, any_letter(), any_letter());
                counted++;
            end
            pair_count = $urandom_range(40, 4);
            repeat (pair_count)
            begin
                pick = $urandom_range(0, 15);
                if (pick == 0)
                    queue_command(3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST)),
                                  any_letter(), any_letter());
                else if (pick == 1)
                    queue_command(CMD_KEY, any_letter(), any_letter());
                else if (pick == 2)
                    queue_command(CMD_FINISH, any_letter(), any_letter());
                else
                begin
                    pair_op = ($urandom_range(0, 1) == 0) ? CMD_ENCRYPT : CMD_DECRYPT;
                    queue_command(pair_op, any_letter(), any_letter());
                end
                counted++;
            end
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // everything handed over, then every owed pair back, then settle
        while (command_queue.size() != 0 || start)
            @(posedge clk);
        while (cipher_pairs_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("tb_playfair_digraph_cipher: PASS");
        else
            $display("tb_playfair_digraph_cipher: FAIL");
        $finish;
    end

endmodule
